// ===== rtl/twkb_pkg.sv =====
// Shared types and constants for the TWKB coordinate decoder.
package twkb_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_TYPE  = 2'd1,
      ST_LONG  = 2'd2,
      ST_STRAY = 2'd3
   } status_type;

   localparam logic [3:0] KIND_POINT      = 4'd1;
   localparam logic [3:0] KIND_MULTIPOINT = 4'd4;

   // One decoded work item handed from the parser to the accumulator.
   typedef struct packed {
      logic [31:0] value;     // raw varint for coordinates, zero for errors
      logic [1:0]  axis;
      logic [31:0] point;
      logic [3:0]  kind;
      logic [3:0]  digits;
      logic        last;
      status_type  status;
      logic        new_geom;  // first coordinate of a geometry: sums start at zero
   } entry_type;

endpackage

// ===== rtl/twkb_front.sv =====
// Byte parser: header, extended dimensions, point count and varint assembly.
module twkb_front #(
   parameter int MAX_AXES = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                first_byte,
   output logic                push,
   output twkb_pkg::entry_type push_entry
);
   import twkb_pkg::*;

   typedef enum logic [4:0] {
      PH_WAIT  = 5'b00001,
      PH_META  = 5'b00010,
      PH_EXT   = 5'b00100,
      PH_COUNT = 5'b01000,
      PH_COORD = 5'b10000
   } phase_type;

   localparam logic [2:0] MAX_AX = 3'(MAX_AXES);

   phase_type   phase_ff, phase_in;
   logic [3:0]  kind_ff, kind_in;
   logic [3:0]  digits_ff, digits_in;
   logic [2:0]  axis_count_ff, axis_count_in;
   logic [31:0] points_left_ff, points_left_in;
   logic [31:0] point_ff, point_in;
   logic [1:0]  axis_ff, axis_in;
   logic [31:0] acc_ff, acc_in;
   logic [2:0]  vbytes_ff, vbytes_in;
   logic        fresh_ff, fresh_in;

   logic [3:0]  type_digits;
   logic [31:0] shifted;
   logic [31:0] acc_new;
   logic [2:0]  ext_count;
   logic [2:0]  axis_next;

   always_comb begin
      type_digits = {1'b0, data_byte[7:5]} ^ {4{data_byte[4]}};
      case (vbytes_ff)
         3'd0: shifted = {25'b0, data_byte[6:0]};
         3'd1: shifted = {18'b0, data_byte[6:0], 7'b0};
         3'd2: shifted = {11'b0, data_byte[6:0], 14'b0};
         3'd3: shifted = {4'b0, data_byte[6:0], 21'b0};
         3'd4: shifted = {data_byte[3:0], 28'b0};
         default: shifted = 32'b0;
      endcase
      acc_new   = acc_ff | shifted;
      ext_count = data_byte[1] ? 3'd4 : 3'd3;
      if (ext_count > MAX_AX) begin
         ext_count = MAX_AX;
      end
      axis_next = {1'b0, axis_ff} + 3'd1;
   end

   always_comb begin
      phase_in       = phase_ff;
      kind_in        = kind_ff;
      digits_in      = digits_ff;
      axis_count_in  = axis_count_ff;
      points_left_in = points_left_ff;
      point_in       = point_ff;
      axis_in        = axis_ff;
      acc_in         = acc_ff;
      vbytes_in      = vbytes_ff;
      fresh_in       = fresh_ff;
      push           = 1'b0;
      push_entry     = '{value: 32'b0, axis: 2'b0, point: 32'b0, kind: kind_ff,
                         digits: digits_ff, last: 1'b1, status: ST_STRAY,
                         new_geom: 1'b0};
      if (accept) begin
         if (first_byte) begin
            kind_in        = data_byte[3:0];
            digits_in      = type_digits;
            axis_count_in  = 3'd2;
            points_left_in = 32'b0;
            point_in       = 32'b0;
            axis_in        = 2'b0;
            acc_in         = 32'b0;
            vbytes_in      = 3'b0;
            fresh_in       = 1'b1;
            if (data_byte[3:0] != KIND_POINT && data_byte[3:0] != KIND_MULTIPOINT) begin
               phase_in          = PH_WAIT;
               push              = 1'b1;
               push_entry.kind   = data_byte[3:0];
               push_entry.digits = type_digits;
               push_entry.status = ST_TYPE;
            end else begin
               phase_in = PH_META;
            end
         end else begin
            case (phase_ff)
               PH_META, PH_EXT: begin
                  if (phase_ff == PH_META && data_byte[3]) begin
                     phase_in = PH_EXT;
                  end else begin
                     axis_count_in = (phase_ff == PH_META) ? 3'd2 : ext_count;
                     if (kind_ff == KIND_MULTIPOINT) begin
                        phase_in = PH_COUNT;
                     end else begin
                        points_left_in = 32'd1;
                        phase_in       = PH_COORD;
                     end
                  end
               end
               PH_COUNT, PH_COORD: begin
                  if (data_byte[7]) begin
                     if (vbytes_ff == 3'd4) begin
                        // A fifth byte that still continues: the varint is too long.
                        phase_in          = PH_WAIT;
                        acc_in            = 32'b0;
                        vbytes_in         = 3'b0;
                        push              = 1'b1;
                        push_entry.axis   = axis_ff;
                        push_entry.point  = point_ff;
                        push_entry.status = ST_LONG;
                     end else begin
                        acc_in    = acc_new;
                        vbytes_in = vbytes_ff + 3'd1;
                     end
                  end else begin
                     acc_in    = 32'b0;
                     vbytes_in = 3'b0;
                     if (phase_ff == PH_COUNT) begin
                        points_left_in = acc_new;
                        phase_in       = (acc_new == 32'b0) ? PH_WAIT : PH_COORD;
                     end else begin
                        push                = 1'b1;
                        push_entry.value    = acc_new;
                        push_entry.axis     = axis_ff;
                        push_entry.point    = point_ff;
                        push_entry.last     = 1'b0;
                        push_entry.status   = ST_OK;
                        push_entry.new_geom = fresh_ff;
                        fresh_in            = 1'b0;
                        if (axis_next >= axis_count_ff) begin
                           axis_in        = 2'b0;
                           point_in       = point_ff + 32'd1;
                           points_left_in = points_left_ff - 32'd1;
                           if (points_left_ff == 32'd1) begin
                              push_entry.last = 1'b1;
                              phase_in        = PH_WAIT;
                           end
                        end else begin
                           axis_in = axis_next[1:0];
                        end
                     end
                  end
               end
               default: begin
                  // Data byte with no geometry open.
                  phase_in = PH_WAIT;
                  push     = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_WAIT;
         kind_ff        <= 4'b0;
         digits_ff      <= 4'b0;
         axis_count_ff  <= 3'd2;
         points_left_ff <= 32'b0;
         point_ff       <= 32'b0;
         axis_ff        <= 2'b0;
         acc_ff         <= 32'b0;
         vbytes_ff      <= 3'b0;
         fresh_ff       <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         kind_ff        <= kind_in;
         digits_ff      <= digits_in;
         axis_count_ff  <= axis_count_in;
         points_left_ff <= points_left_in;
         point_ff       <= point_in;
         axis_ff        <= axis_in;
         acc_ff         <= acc_in;
         vbytes_ff      <= vbytes_in;
         fresh_ff       <= fresh_in;
      end
   end

endmodule

// ===== rtl/twkb_queue.sv =====
// Short first-in first-out queue between the parser and the accumulator.
module twkb_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  twkb_pkg::entry_type push_entry,
   input  logic                pop,
   output twkb_pkg::entry_type head,
   output logic                full,
   output logic                empty
);
   import twkb_pkg::*;

   entry_type         slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   always_comb begin
      full      = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
      empty     = (count_ff == '0);
      head      = slots_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/twkb_back.sv =====
// Accumulator: zigzag decode, per-axis running sums and the result register.
module twkb_back #(
   parameter int MAX_AXES = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  twkb_pkg::entry_type head,
   input  logic                empty,
   output logic                pop,
   input  logic                out_ready,
   output logic                out_valid,
   output twkb_pkg::entry_type out_entry
);
   import twkb_pkg::*;

   localparam int AXW = (MAX_AXES > 2) ? 2 : 1;

   logic [31:0]    sum_ff [MAX_AXES];
   logic [31:0]    sum_in [MAX_AXES];
   logic           out_valid_ff, out_valid_in;
   entry_type      out_ff, out_in;

   logic [AXW-1:0] ax;
   logic [31:0]    delta;
   logic [31:0]    base;
   logic [31:0]    sum_new;

   always_comb begin
      pop     = !empty && (!out_valid_ff || out_ready);
      ax      = head.axis[AXW-1:0];
      delta   = {1'b0, head.value[31:1]} ^ {32{head.value[0]}};
      base    = head.new_geom ? 32'b0 : sum_ff[ax];
      sum_new = base + delta;

      for (int i = 0; i < MAX_AXES; i++) begin
         sum_in[i] = sum_ff[i];
      end
      out_in = out_ff;
      if (pop) begin
         out_in = head;
         if (head.status == ST_OK) begin
            for (int i = 0; i < MAX_AXES; i++) begin
               sum_in[i] = head.new_geom ? 32'b0 : sum_ff[i];
            end
            sum_in[ax]   = sum_new;
            out_in.value = sum_new;
         end
      end

      if (pop) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      for (int i = 0; i < MAX_AXES; i++) begin
         sum_ff[i] <= sum_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_entry = out_ff;

   // Error results always close the geometry and carry no coordinate.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.status != ST_OK |-> out_ff.last && out_ff.value == 32'b0)
      else $error("error transaction with coordinate or without last");

   // The first coordinate of a geometry is its own delta.
   assert property (@(posedge clock) disable iff (reset)
      pop && head.new_geom && head.status == ST_OK |=> out_ff.value == $past(delta))
      else $error("running sum not restarted at geometry start");

   // No bubble: a queued item moves on whenever the result register can take it.
   assert property (@(posedge clock) disable iff (reset)
      !empty && (!out_valid_ff || out_ready) |-> pop)
      else $error("accumulator stalled with work queued");

endmodule

// ===== rtl/twkb_coordinate_decoder.sv =====
// Top level of the TWKB coordinate decoder.
//
// The req_ channel takes one byte of an encoded geometry per transaction;
// req_tuser is high on the type byte that opens a geometry and restarts any
// geometry in progress. The rsp_ channel gives one transaction per finished
// coordinate, or one per error, with rsp_tlast on the final coordinate of a
// geometry and on every error; rsp_tuser carries the status code.
// Coordinates are integers scaled by ten to the decoded precision.
// The parser writes each decoded varint into a four-entry queue at the edge
// that accepts the byte completing it; the accumulator pops it into the result
// register once that register is empty or its result is being taken, so a
// stall on rsp_ can hold it in the queue. The block takes one byte per cycle
// while the queue is not full, set by the parser, which handles each accepted
// byte as it comes, and the single adder of the accumulator. When the receiver
// stalls, results wait in the queue and the result register; req_tready drops
// only when the queue is full or reset is high. Reset clears the parser, the
// queue pointers and the result valid flag; bytes are taken once reset is low.
module twkb_coordinate_decoder #(
   parameter int MAX_AXES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] first_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] coord_value, [33:32] axis_index, [65:34] point_index,
   // [69:66] geom_kind, [73:70] scale_digits, [79:74] zero
   output logic [79:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast
);
   import twkb_pkg::*;

   logic      accept;
   logic      push;
   entry_type push_entry;
   entry_type head;
   logic      pop;
   logic      full;
   logic      empty;
   entry_type out_entry;

   assign req_tready = !full && !reset;
   assign accept     = req_tvalid && req_tready;

   twkb_front #(.MAX_AXES(MAX_AXES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_tdata),
      .first_byte (req_tuser[0]),
      .push       (push),
      .push_entry (push_entry)
   );

   twkb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (full),
      .empty      (empty)
   );

   twkb_back #(.MAX_AXES(MAX_AXES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (empty),
      .pop       (pop),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_entry (out_entry)
   );

   assign rsp_tdata = {6'b0, out_entry.digits, out_entry.kind, out_entry.point,
                       out_entry.axis, out_entry.value};
   assign rsp_tuser = out_entry.status;
   assign rsp_tlast = out_entry.last;

endmodule
